// ===== hdl/gn3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared types and constants of the three-dimensional gradient noise block.
// ----------------------------------------------------------------------------
package gn3_pkg;

    // permutation table geometry
    localparam int TABLE_BITS = 8;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;

    // word field widths
    localparam int COORD_W = 32;
    localparam int LEVEL_W = 17;

    // default number of fraction bits in a coordinate
    localparam int FRACTION_BITS_DEF = 16;

    // output scale: Q1.16, saturated to one
    localparam int OUT_FRAC_BITS = 16;
    localparam int LEVEL_MAX     = 1 << OUT_FRAC_BITS;

    // register stages from input to output register
    localparam int NUM_STAGES = 14;

    // operating modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // gradient selection codes on the low four hash bits
    localparam logic [3:0] GRAD_U_FROM_Y = 4'd8;
    localparam logic [3:0] GRAD_V_FROM_Y = 4'd4;
    localparam logic [3:0] GRAD_V_X_A    = 4'd12;
    localparam logic [3:0] GRAD_V_X_B    = 4'd14;

    typedef logic [TABLE_BITS-1:0] t_tab;

    // pipeline control: advance enables per stage and valid bits (v[0] = input)
    typedef struct packed {
        logic [NUM_STAGES:1] en;
        logic [NUM_STAGES:0] v;
    } t_pipe_ctl;

endpackage

// ===== hdl/gn3_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_in_if / gn3_out_if
// Valid/ready channels carrying input words and noise result words.
// ----------------------------------------------------------------------------
interface gn3_in_if
    import gn3_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [TABLE_BITS-1:0]     table_index;
    logic [TABLE_BITS-1:0]     table_value;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;

    modport source (output valid, mode, table_index, table_value, coord_x, coord_y, coord_z,
                    input ready);
    modport sink   (input valid, mode, table_index, table_value, coord_x, coord_y, coord_z,
                    output ready);
endinterface

interface gn3_out_if
    import gn3_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] noise_level;

    modport source (output valid, noise_level, input ready);
    modport sink   (input valid, noise_level, output ready);
endinterface

// ===== hdl/gn3_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_hash
// Three stages of corner hashing through replicated permutation tables.
// Each copy is written when a load word passes the stage that reads it.
// ----------------------------------------------------------------------------
module gn3_hash
    import gn3_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  logic      i_mode,
    input  t_tab      i_table_index,
    input  t_tab      i_table_value,
    input  t_tab      i_cell_x,
    input  t_tab      i_cell_y,
    input  t_tab      i_cell_z,
    output logic      o_mode,
    output t_tab      o_hash [8]
);

    logic wr1, wr2, wr3;

    // stage 1 registers
    logic r_mode1;
    t_tab r_idx1, r_val1, r_cy1, r_cz1, r_tx, r_tx1;
    // stage 2 registers
    logic r_mode2;
    t_tab r_idx2, r_val2, r_cz2;
    t_tab r_t2 [4];
    // stage 3 registers
    logic r_mode3;
    t_tab r_h [8];

    t_tab mem0 [TABLE_SIZE];
    t_tab s2_addr [2];
    t_tab s3_base [4];

    assign wr1 = i_ctl.en[1] && i_ctl.v[0] && (i_mode == MODE_LOAD);
    assign wr2 = i_ctl.en[2] && i_ctl.v[1] && (r_mode1 == MODE_LOAD);
    assign wr3 = i_ctl.en[3] && i_ctl.v[2] && (r_mode2 == MODE_LOAD);

    // stage 1: first table copy, rows x and x+1
    always_ff @(posedge i_clk) begin
        if (wr1) begin
            mem0[i_table_index] <= i_table_value;
        end
        if (i_ctl.en[1]) begin
            r_tx    <= mem0[i_cell_x];
            r_tx1   <= mem0[t_tab'(i_cell_x + 1'b1)];
            r_mode1 <= i_mode;
            r_idx1  <= i_table_index;
            r_val1  <= i_table_value;
            r_cy1   <= i_cell_y;
            r_cz1   <= i_cell_z;
        end
    end

    // stage 2: hashes a and b, two copies
    assign s2_addr[0] = t_tab'(r_tx + r_cy1);
    assign s2_addr[1] = t_tab'(r_tx1 + r_cy1);

    for (genvar c = 0; c < 2; c++) begin : g_s2
        t_tab mem [TABLE_SIZE];
        always_ff @(posedge i_clk) begin
            if (wr2) begin
                mem[r_idx1] <= r_val1;
            end
            if (i_ctl.en[2]) begin
                r_t2[2*c]   <= mem[s2_addr[c]];
                r_t2[2*c+1] <= mem[t_tab'(s2_addr[c] + 1'b1)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_mode2 <= r_mode1;
            r_idx2  <= r_idx1;
            r_val2  <= r_val1;
            r_cz2   <= r_cz1;
        end
    end

    // stage 3: hashes aa, ab, ba, bb and their z neighbours, four copies
    assign s3_base[0] = t_tab'(r_t2[0] + r_cz2);
    assign s3_base[1] = t_tab'(r_t2[1] + r_cz2);
    assign s3_base[2] = t_tab'(r_t2[2] + r_cz2);
    assign s3_base[3] = t_tab'(r_t2[3] + r_cz2);

    for (genvar c = 0; c < 4; c++) begin : g_s3
        // corner slot: bit 0 = x neighbour, bit 1 = y neighbour
        localparam int SLOT = ((c % 2) * 2) + (c / 2);
        t_tab mem [TABLE_SIZE];
        always_ff @(posedge i_clk) begin
            if (wr3) begin
                mem[r_idx2] <= r_val2;
            end
            if (i_ctl.en[3]) begin
                r_h[SLOT]     <= mem[s3_base[c]];
                r_h[SLOT + 4] <= mem[t_tab'(s3_base[c] + 1'b1)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_mode3 <= r_mode2;
        end
    end

    assign o_mode = r_mode3;
    assign o_hash = r_h;

endmodule

// ===== hdl/gn3_fade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_fade
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 of one fraction, rounded
// products, clamped to zero..one. The fraction travels alongside.
// ----------------------------------------------------------------------------
module gn3_fade
    import gn3_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic [3:1]               i_en,
    input  logic [FRACTION_BITS-1:0] i_frac,
    output logic [FRACTION_BITS:0]   o_fade,
    output logic [FRACTION_BITS-1:0] o_frac
);

    localparam int F  = FRACTION_BITS;
    localparam int W  = F + 6;
    localparam int PW = 2 * W;
    localparam logic signed [W-1:0]  ONE_Q  = W'(1) << F;
    localparam logic signed [W-1:0]  C15    = W'(15) << F;
    localparam logic signed [W-1:0]  C10    = W'(10) << F;
    localparam logic signed [PW-1:0] HALF_Q = PW'(1) << (F - 1);

    function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = (p + HALF_Q) >>> F;
        return s[W-1:0];
    endfunction

    logic signed [W-1:0]  ts, lin, ts1;
    logic signed [PW-1:0] p1, p2, p3, p4;
    logic signed [W-1:0]  r_m1, r_m2, r_inner, r_t3, f;
    logic [F-1:0]         r_f1, r_f2, r_f3;
    logic [F:0]           r_fade;

    assign ts  = W'({1'b0, i_frac});
    assign lin = (ts <<< 2) + (ts <<< 1) - C15;
    assign p1  = ts * lin;
    assign p2  = ts * ts;
    assign ts1 = W'({1'b0, r_f1});
    assign p3  = r_m2 * ts1;
    assign p4  = r_t3 * r_inner;
    assign f   = rnd(p4);

    always_ff @(posedge i_clk) begin
        // stage 1: t*(6t-15) and t*t
        if (i_en[1]) begin
            r_m1 <= rnd(p1);
            r_m2 <= rnd(p2);
            r_f1 <= i_frac;
        end
        // stage 2: inner term and t^3
        if (i_en[2]) begin
            r_inner <= r_m1 + C10;
            r_t3    <= rnd(p3);
            r_f2    <= r_f1;
        end
        // stage 3: product and clamp
        if (i_en[3]) begin
            if (f < 0) begin
                r_fade <= '0;
            end else if (f > ONE_Q) begin
                r_fade <= ONE_Q[F:0];
            end else begin
                r_fade <= f[F:0];
            end
            r_f3 <= r_f2;
        end
    end

    assign o_fade = r_fade;
    assign o_frac = r_f3;

endmodule

// ===== hdl/gn3_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_lerp
// One interpolation level over several lanes: difference, rounded product,
// add. Side data is delayed with the lanes.
// ----------------------------------------------------------------------------
module gn3_lerp
    import gn3_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int LANES         = 4,
    parameter int SIDE_W        = 1
) (
    input  logic                            i_clk,
    input  logic [3:1]                      i_en,
    input  logic signed [FRACTION_BITS+5:0] i_a [LANES],
    input  logic signed [FRACTION_BITS+5:0] i_b [LANES],
    input  logic [FRACTION_BITS:0]          i_t,
    input  logic [SIDE_W-1:0]               i_side,
    output logic signed [FRACTION_BITS+5:0] o_y [LANES],
    output logic [SIDE_W-1:0]               o_side
);

    localparam int F  = FRACTION_BITS;
    localparam int W  = F + 6;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam logic signed [PW-1:0] HALF_Q = PW'(1) << (F - 1);

    logic signed [W-1:0]  r_a1 [LANES];
    logic signed [W-1:0]  r_a2 [LANES];
    logic signed [DW-1:0] r_d  [LANES];
    logic signed [PW-1:0] r_p  [LANES];
    logic signed [W-1:0]  r_y  [LANES];
    logic [F:0]           r_t;
    logic signed [DW-1:0] ts;
    logic [SIDE_W-1:0]    r_s1, r_s2, r_s3;

    assign ts = DW'({1'b0, r_t});

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [PW-1:0] sh;
        assign sh = (r_p[l] + HALF_Q) >>> F;
        always_ff @(posedge i_clk) begin
            // difference
            if (i_en[1]) begin
                r_a1[l] <= i_a[l];
                r_d[l]  <= DW'(i_b[l]) - DW'(i_a[l]);
            end
            // product with the blend weight
            if (i_en[2]) begin
                r_a2[l] <= r_a1[l];
                r_p[l]  <= ts * r_d[l];
            end
            // round and add
            if (i_en[3]) begin
                r_y[l] <= r_a2[l] + sh[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t  <= i_t;
            r_s1 <= i_side;
        end
        if (i_en[2]) begin
            r_s2 <= r_s1;
        end
        if (i_en[3]) begin
            r_s3 <= r_s2;
        end
    end

    assign o_y    = r_y;
    assign o_side = r_s3;

endmodule

// ===== hdl/gradient_noise_3d.sv =====
`timescale 1ns / 1ps
// An accepted word passes the hash, fade, gradient and blend stages to its result word in the output register.
// Throughput: one word per cycle; each pipeline stage holds under backpressure.
// Table reads use seven copies of the permutation table, two read ports each.
// Load words give no result; they trail earlier evaluations.
// Reset clears the valid bits only; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved gradient noise in three dimensions: hash, fade, gradients,
// trilinear blend, and mapping to an unsigned Q1.16 level.
// ----------------------------------------------------------------------------
module gradient_noise_3d
    import gn3_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gn3_in_if.sink    i_in,
    gn3_out_if.source o_out
);

    localparam int F  = FRACTION_BITS;
    localparam int W  = F + 6;
    localparam int RW = W + 10;
    localparam logic signed [W-1:0] ONE_Q = W'(1) << F;

    t_pipe_ctl            ctl;
    logic [NUM_STAGES:1]  r_v;
    logic [NUM_STAGES:1]  en;
    logic                 mode3;
    t_tab                 hash3 [8];
    logic [F:0]           fade3 [3];
    logic [F-1:0]         frac3 [3];

    logic signed [W-1:0]  r_g  [8];
    logic [F:0]           r_u4, r_v4, r_w4;
    logic signed [W-1:0]  ga [4];
    logic signed [W-1:0]  gb [4];
    logic signed [W-1:0]  lx [4];
    logic signed [W-1:0]  ya [2];
    logic signed [W-1:0]  yb [2];
    logic signed [W-1:0]  ly [2];
    logic signed [W-1:0]  za [1];
    logic signed [W-1:0]  zb [1];
    logic signed [W-1:0]  lz [1];
    logic [2*F+1:0]       side_x;
    logic [F:0]           side_y;
    logic [F:0]           side_z;
    logic [LEVEL_W-1:0]   r_level;
    logic [LEVEL_W-1:0]   n_level;

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        en[NUM_STAGES] = !r_v[NUM_STAGES] || o_out.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign ctl.en = en;
    assign ctl.v  = {r_v, i_in.valid};
    assign i_in.ready = en[1];

    // valid bits; load words leave after the hash stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NUM_STAGES; k++) begin
                if (en[k]) begin
                    if (k == 4) begin
                        r_v[k] <= r_v[3] && (mode3 == MODE_EVAL);
                    end else begin
                        r_v[k] <= ctl.v[k-1];
                    end
                end
            end
        end
    end

    gn3_hash u_hash (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_mode        (i_in.mode),
        .i_table_index (i_in.table_index),
        .i_table_value (i_in.table_value),
        .i_cell_x      (i_in.coord_x[F+TABLE_BITS-1:F]),
        .i_cell_y      (i_in.coord_y[F+TABLE_BITS-1:F]),
        .i_cell_z      (i_in.coord_z[F+TABLE_BITS-1:F]),
        .o_mode        (mode3),
        .o_hash        (hash3)
    );

    gn3_fade #(.FRACTION_BITS(F)) u_fade_x (
        .i_clk (i_clk), .i_en (en[3:1]), .i_frac (i_in.coord_x[F-1:0]),
        .o_fade (fade3[0]), .o_frac (frac3[0])
    );
    gn3_fade #(.FRACTION_BITS(F)) u_fade_y (
        .i_clk (i_clk), .i_en (en[3:1]), .i_frac (i_in.coord_y[F-1:0]),
        .o_fade (fade3[1]), .o_frac (frac3[1])
    );
    gn3_fade #(.FRACTION_BITS(F)) u_fade_z (
        .i_clk (i_clk), .i_en (en[3:1]), .i_frac (i_in.coord_z[F-1:0]),
        .o_fade (fade3[2]), .o_frac (frac3[2])
    );

    // gradient dot product of one corner
    function automatic logic signed [W-1:0] grad(
        input t_tab                h,
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] y,
        input logic signed [W-1:0] z
    );
        logic [3:0]          c;
        logic signed [W-1:0] u;
        logic signed [W-1:0] v;
        c = h[3:0];
        u = (c < GRAD_U_FROM_Y) ? x : y;
        if (c < GRAD_V_FROM_Y) begin
            v = y;
        end else if (c == GRAD_V_X_A || c == GRAD_V_X_B) begin
            v = x;
        end else begin
            v = z;
        end
        return (c[0] ? -u : u) + (c[1] ? -v : v);
    endfunction

    // stage 4: eight corner gradients and fade weights
    for (genvar k = 0; k < 8; k++) begin : g_corner
        localparam bit X1 = (k & 1) != 0;
        localparam bit Y1 = (k & 2) != 0;
        localparam bit Z1 = (k & 4) != 0;
        logic signed [W-1:0] cx, cy, cz;
        assign cx = W'({1'b0, frac3[0]}) - (X1 ? ONE_Q : W'(0));
        assign cy = W'({1'b0, frac3[1]}) - (Y1 ? ONE_Q : W'(0));
        assign cz = W'({1'b0, frac3[2]}) - (Z1 ? ONE_Q : W'(0));
        always_ff @(posedge i_clk) begin
            if (en[4]) begin
                r_g[k] <= grad(hash3[k], cx, cy, cz);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_u4 <= fade3[0];
            r_v4 <= fade3[1];
            r_w4 <= fade3[2];
        end
    end

    // blend along x, then y, then z
    for (genvar j = 0; j < 4; j++) begin : g_lx
        assign ga[j] = r_g[2*j];
        assign gb[j] = r_g[2*j+1];
    end

    gn3_lerp #(.FRACTION_BITS(F), .LANES(4), .SIDE_W(2*F+2)) u_lerp_x (
        .i_clk (i_clk), .i_en (en[7:5]), .i_a (ga), .i_b (gb), .i_t (r_u4),
        .i_side ({r_v4, r_w4}), .o_y (lx), .o_side (side_x)
    );

    for (genvar j = 0; j < 2; j++) begin : g_ly
        assign ya[j] = lx[2*j];
        assign yb[j] = lx[2*j+1];
    end

    gn3_lerp #(.FRACTION_BITS(F), .LANES(2), .SIDE_W(F+1)) u_lerp_y (
        .i_clk (i_clk), .i_en (en[10:8]), .i_a (ya), .i_b (yb),
        .i_t (side_x[2*F+1:F+1]), .i_side (side_x[F:0]), .o_y (ly), .o_side (side_y)
    );

    assign za[0] = ly[0];
    assign zb[0] = ly[1];

    gn3_lerp #(.FRACTION_BITS(F), .LANES(1), .SIDE_W(F+1)) u_lerp_z (
        .i_clk (i_clk), .i_en (en[13:11]), .i_a (za), .i_b (zb),
        .i_t (side_y), .i_side (side_y), .o_y (lz), .o_side (side_z)
    );

    // map noise+1 onto Q1.16 and saturate
    logic signed [RW-1:0] r_sum;
    logic signed [RW-1:0] scaled;

    assign r_sum = RW'(lz[0]) + RW'(ONE_Q);

    if (F > OUT_FRAC_BITS - 1) begin : g_down
        localparam int SH = F - (OUT_FRAC_BITS - 1);
        if (SH > 0) begin : g_round
            assign scaled = (r_sum + (RW'(1) << (SH - 1))) >>> SH;
        end else begin : g_same
            assign scaled = r_sum;
        end
    end else begin : g_up
        assign scaled = r_sum <<< ((OUT_FRAC_BITS - 1) - F);
    end

    always_comb begin
        if (r_sum <= 0) begin
            n_level = '0;
        end else if (scaled > RW'(LEVEL_MAX)) begin
            n_level = LEVEL_W'(LEVEL_MAX);
        end else begin
            n_level = scaled[LEVEL_W-1:0];
        end
    end

    // stage 14: output register
    always_ff @(posedge i_clk) begin
        if (en[14]) begin
            r_level <= n_level;
        end
    end

    assign o_out.valid       = r_v[NUM_STAGES];
    assign o_out.noise_level = r_level;

endmodule
